// ----- sv/wps_pkg.sv -----
// shared constants, codes and types for the wildcard pattern search block
// no dependencies
package wps_pkg;

	localparam int PAT_DEPTH   = 64;
	localparam int PAT_AW      = $clog2(PAT_DEPTH);
	localparam int PAT_CW      = PAT_AW + 1;
	localparam int SRC_DEPTH   = 1024;
	localparam int SRC_AW      = $clog2(SRC_DEPTH);
	localparam int SRC_CW      = SRC_AW + 1;
	localparam int RETRY_DEPTH = 16;
	localparam int RETRY_AW    = $clog2(RETRY_DEPTH);
	localparam int RETRY_CW    = RETRY_AW + 1;
	localparam int PPOS_W      = PAT_CW + 1;
	localparam int PADDR_W     = 3;

	localparam logic [7:0] STAR_BYTE   = 8'h2a;
	localparam logic [7:0] ANY_BYTE    = 8'h23;
	localparam logic [7:0] CHAR_UP_A   = 8'h41;
	localparam logic [7:0] CHAR_UP_Z   = 8'h5a;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic REG_MATCH_CASE = 1'b0;

	typedef enum logic [1:0] {
		OP_CLEAR      = 2'd0,
		OP_APPEND_PAT = 2'd1,
		OP_APPEND_SRC = 2'd2,
		OP_SEARCH     = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_APPEND_PAT,
		CMD_APPEND_SRC,
		CMD_START,
		CMD_READ_P,
		CMD_SKIP,
		CMD_LATCH_CH,
		CMD_READ_S,
		CMD_SCAN_NEXT,
		CMD_STAR_OK,
		CMD_LIT_OK,
		CMD_POP
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic out_load;
		logic out_hit;
	} wps_ctrl_t;

	typedef struct packed {
		logic p_neg;
		logic p_end;
		logic pd_star;
		logic pd_any;
		logic s_end;
		logic scan_hit;
		logic lit_ok;
		logic top_zero;
	} wps_stat_t;

	function automatic logic [7:0] view_byte(input logic [7:0] c, input logic exact);
		logic [7:0] r;
		r = c;
		if (!exact && c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

// ----- sv/wps_ifs.sv -----
// valid/ready channel interfaces for input items and search results
// depends on wps_pkg
interface wps_in_if import wps_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] data_byte;
	modport source (output valid, op, data_byte, input ready);
	modport sink (input valid, op, data_byte, output ready);
endinterface

interface wps_out_if import wps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              found;
	logic [SRC_AW-1:0] match_start;
	logic [SRC_CW-1:0] match_length;
	logic              overflowed;
	modport source (output valid, found, match_start, match_length, overflowed, input ready);
	modport sink (input valid, found, match_start, match_length, overflowed, output ready);
endinterface

// ----- sv/wps_ctrl.sv -----
// sequencer for appends and the backtracking search walk
// depends on wps_pkg
module wps_ctrl import wps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic [1:0] in_op,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  wps_stat_t stat,
	output wps_ctrl_t ctrl
);

	typedef enum logic [9:0] {
		ST_IDLE      = 10'b0000000001,
		ST_LOOP      = 10'b0000000010,
		ST_P_EVAL    = 10'b0000000100,
		ST_SKIP_EVAL = 10'b0000001000,
		ST_SCAN_FET  = 10'b0000010000,
		ST_SCAN_EVAL = 10'b0000100000,
		ST_DECIDE    = 10'b0001000000,
		ST_LIT_EVAL  = 10'b0010000000,
		ST_POP       = 10'b0100000000,
		ST_DONE      = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   hit_q, hit_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		hit_d         = hit_q;
		ctrl.cmd      = CMD_NONE;
		ctrl.out_load = 1'b0;
		ctrl.out_hit  = hit_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (op_t'(in_op))
						OP_CLEAR:      ctrl.cmd = CMD_CLEAR;
						OP_APPEND_PAT: ctrl.cmd = CMD_APPEND_PAT;
						OP_APPEND_SRC: ctrl.cmd = CMD_APPEND_SRC;
						OP_SEARCH: begin
							ctrl.cmd = CMD_START;
							state_d  = ST_LOOP;
						end
						default: ctrl.cmd = CMD_NONE;
					endcase
				end
			end
			ST_LOOP: begin
				if (stat.p_end) begin
					hit_d   = 1'b1;
					state_d = ST_DONE;
				end else if (stat.p_neg) begin
					ctrl.cmd = CMD_SKIP;
					state_d  = ST_SKIP_EVAL;
				end else begin
					ctrl.cmd = CMD_READ_P;
					state_d  = ST_P_EVAL;
				end
			end
			ST_P_EVAL: begin
				if (stat.pd_star) begin
					ctrl.cmd = CMD_SKIP;
					state_d  = ST_SKIP_EVAL;
				end else if (stat.s_end) begin
					state_d = ST_POP;
				end else begin
					ctrl.cmd = CMD_READ_S;
					state_d  = ST_LIT_EVAL;
				end
			end
			ST_SKIP_EVAL: begin
				if (stat.p_end) begin
					hit_d   = 1'b1;
					state_d = ST_DONE;
				end else if (stat.pd_star) begin
					ctrl.cmd = CMD_SKIP;
				end else begin
					ctrl.cmd = CMD_LATCH_CH;
					state_d  = stat.pd_any ? ST_DECIDE : ST_SCAN_FET;
				end
			end
			ST_SCAN_FET: begin
				if (stat.s_end) begin
					state_d = ST_DECIDE;
				end else begin
					ctrl.cmd = CMD_READ_S;
					state_d  = ST_SCAN_EVAL;
				end
			end
			ST_SCAN_EVAL: begin
				if (stat.scan_hit) begin
					state_d = ST_DECIDE;
				end else begin
					ctrl.cmd = CMD_SCAN_NEXT;
					state_d  = ST_SCAN_FET;
				end
			end
			ST_DECIDE: begin
				if (stat.s_end) begin
					state_d = ST_POP;
				end else begin
					ctrl.cmd = CMD_STAR_OK;
					state_d  = ST_LOOP;
				end
			end
			ST_LIT_EVAL: begin
				if (stat.lit_ok) begin
					ctrl.cmd = CMD_LIT_OK;
					state_d  = ST_LOOP;
				end else begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				if (stat.top_zero) begin
					hit_d   = 1'b0;
					state_d = ST_DONE;
				end else begin
					ctrl.cmd = CMD_POP;
					state_d  = ST_LOOP;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					ctrl.out_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hit_q   <= hit_d;
			if (ctrl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/wps_dp.sv -----
// stores, walk pointers, retry stack and result register
// depends on wps_pkg
module wps_dp import wps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  wps_ctrl_t           ctrl,
	input  logic [7:0]          data_byte,
	input  logic                match_case,
	output wps_stat_t           stat,
	output logic                found,
	output logic [SRC_AW-1:0]   match_start,
	output logic [SRC_CW-1:0]   match_length,
	output logic                overflowed
);

	typedef struct packed {
		logic [SRC_AW-1:0]        ms;
		logic [SRC_CW-1:0]        src;
		logic signed [PPOS_W-1:0] pat;
		logic                     first;
	} retry_t;

	logic [7:0]  pat_mem [PAT_DEPTH];
	logic [7:0]  src_mem [SRC_DEPTH];
	retry_t      retry_q [RETRY_DEPTH];

	logic [PAT_CW-1:0]        pat_cnt_q;
	logic [SRC_CW-1:0]        src_cnt_q;
	logic                     dropped_q;
	logic [RETRY_CW-1:0]      top_q;
	logic signed [PPOS_W-1:0] p_q, p_inc;
	logic [SRC_CW-1:0]        s_q, s_inc;
	logic [SRC_AW-1:0]        ms_q;
	logic                     first_q;
	logic [7:0]               pd_q, sd_q, ch_q;
	logic [SRC_CW-1:0]        span;
	retry_t                   top_ent;

	assign p_inc   = p_q + PPOS_W'(1);
	assign s_inc   = s_q + SRC_CW'(1);
	assign top_ent = retry_q[top_q[RETRY_AW-1:0] - RETRY_AW'(1)];
	assign span    = s_q - SRC_CW'(ms_q);

	always_comb begin
		stat.p_neg    = p_q[PPOS_W-1];
		stat.p_end    = !p_q[PPOS_W-1] && (p_q[PAT_CW-1:0] >= pat_cnt_q);
		stat.pd_star  = (pd_q == STAR_BYTE);
		stat.pd_any   = (pd_q == ANY_BYTE);
		stat.s_end    = (s_q >= src_cnt_q);
		stat.scan_hit = view_byte(sd_q, match_case) == view_byte(ch_q, match_case);
		stat.lit_ok   = (pd_q == ANY_BYTE) ||
		                (view_byte(sd_q, match_case) == view_byte(pd_q, match_case));
		stat.top_zero = (top_q == '0);
	end

	// store and retry stack writes, registered reads and the result register
	always_ff @(posedge clk) begin
		if (ctrl.cmd == CMD_APPEND_PAT && !pat_cnt_q[PAT_CW-1]) begin
			pat_mem[pat_cnt_q[PAT_AW-1:0]] <= data_byte;
		end
		if (ctrl.cmd == CMD_APPEND_SRC && !src_cnt_q[SRC_CW-1]) begin
			src_mem[src_cnt_q[SRC_AW-1:0]] <= data_byte;
		end
		if (ctrl.cmd == CMD_READ_P) begin
			pd_q <= pat_mem[p_q[PAT_AW-1:0]];
		end else if (ctrl.cmd == CMD_SKIP) begin
			pd_q <= pat_mem[p_inc[PAT_AW-1:0]];
		end
		if (ctrl.cmd == CMD_READ_S) begin
			sd_q <= src_mem[s_q[SRC_AW-1:0]];
		end
		if (ctrl.cmd == CMD_LATCH_CH) begin
			ch_q <= pd_q;
		end
		if (ctrl.cmd == CMD_STAR_OK && !top_q[RETRY_CW-1]) begin
			retry_q[top_q[RETRY_AW-1:0]] <= '{ms: ms_q, src: s_inc,
				pat: p_q - PPOS_W'(1), first: first_q};
		end
		if (ctrl.out_load) begin
			found        <= ctrl.out_hit;
			match_start  <= ctrl.out_hit ? ms_q : '0;
			match_length <= !ctrl.out_hit ? '0 :
			                (span == '0) ? SRC_CW'(1) : span;
			overflowed   <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_cnt_q <= '0;
			src_cnt_q <= '0;
			dropped_q <= 1'b0;
			top_q     <= '0;
			p_q       <= '0;
			s_q       <= '0;
			ms_q      <= '0;
			first_q   <= 1'b1;
		end else begin
			case (ctrl.cmd)
				CMD_CLEAR: begin
					pat_cnt_q <= '0;
					src_cnt_q <= '0;
					dropped_q <= 1'b0;
				end
				CMD_APPEND_PAT: begin
					if (pat_cnt_q[PAT_CW-1]) dropped_q <= 1'b1;
					else pat_cnt_q <= pat_cnt_q + PAT_CW'(1);
				end
				CMD_APPEND_SRC: begin
					if (src_cnt_q[SRC_CW-1]) dropped_q <= 1'b1;
					else src_cnt_q <= src_cnt_q + SRC_CW'(1);
				end
				CMD_START: begin
					p_q     <= '1;
					s_q     <= '0;
					ms_q    <= '0;
					first_q <= 1'b1;
					top_q   <= '0;
				end
				CMD_SKIP: p_q <= p_inc;
				CMD_SCAN_NEXT: s_q <= s_inc;
				CMD_STAR_OK, CMD_LIT_OK: begin
					if (ctrl.cmd == CMD_STAR_OK && !top_q[RETRY_CW-1]) begin
						top_q <= top_q + RETRY_CW'(1);
					end
					if (first_q) begin
						ms_q    <= s_q[SRC_AW-1:0];
						first_q <= 1'b0;
					end
					p_q <= p_inc;
					s_q <= s_inc;
				end
				CMD_POP: begin
					top_q   <= top_q - RETRY_CW'(1);
					ms_q    <= top_ent.ms;
					s_q     <= top_ent.src;
					p_q     <= top_ent.pat;
					first_q <= top_ent.first;
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- sv/wildcard_pattern_search.sv -----
// top level of the wildcard pattern search block: apb register and the two halves
// depends on wps_pkg, wps_ifs, wps_ctrl, wps_dp
//
// Items on the input channel either clear both stores, append one byte to the
// 64-byte pattern store or the 1024-byte source store, or run a search. Clear
// and append transactions return nothing; an append to a full store is dropped
// and raises the overflowed flag until the next clear. A search returns one
// result transaction: '*' matches any run of bytes, '#' one byte, anything
// else itself, and the match may begin anywhere in the source. The walk is a
// sequencer over single-port stores with registered reads: each literal is
// read from the pattern, then the source byte is read and compared; each run
// of stars is skipped one star at a time, then the source is scanned byte by
// byte for the next pattern byte (unless it is '#') and the match is taken; a
// backtrack pops a retry point; and the result is loaded last. The input is
// held off while a search runs and while a finished result waits for the
// output register to free up. It keeps up to 16 retry points; further ones
// are dropped and may miss a match. The match-case register at address 0
// selects exact compare (1) or folding of A-Z (0); write it only while the
// block is idle.
module wildcard_pattern_search import wps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	wps_in_if.sink             in_ch,
	wps_out_if.source          out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	wps_ctrl_t ctrl;
	wps_stat_t stat;
	logic      match_case_q;
	logic      reg_hit;

	// one register, selected by the word address bit
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_MATCH_CASE);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {31'b0, match_case_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_case_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_hit) begin
			match_case_q <= pwdata[0];
		end
	end

	// controller walks the search, datapath holds stores and pointers
	wps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_op     (in_ch.op),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	wps_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.data_byte      (in_ch.data_byte),
		.match_case     (match_case_q),
		.stat           (stat),
		.found          (out_ch.found),
		.match_start    (out_ch.match_start),
		.match_length   (out_ch.match_length),
		.overflowed     (out_ch.overflowed)
	);

endmodule
